// ----- rtl/scl_pkg.sv -----
package scl_pkg;

  // Default line buffer size; one slot is reserved, so LINE_BYTES - 1 bytes are kept.
  localparam int LINE_BYTES_DEF = 32;

  // Number of bytes that form the command prefix.
  localparam int PREFIX_LEN = 4;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] DIGIT_ZERO   = 8'h30;
  localparam logic [7:0] DIGIT_NINE   = 8'h39;

  localparam logic [31:0] PREFIX_ROT = 32'h524F_5420;
  localparam logic [31:0] PREFIX_TEM = 32'h5445_4D20;
  localparam logic [31:0] PREFIX_VAC = 32'h5641_4320;

  typedef enum logic [1:0] {
    KIND_ROT     = 2'd0,
    KIND_TEM     = 2'd1,
    KIND_VAC     = 2'd2,
    KIND_INVALID = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
  } result_t;

endpackage

// ----- rtl/scl_in_stage.sv -----
module scl_in_stage
  import scl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rx_byte,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  // The held beat leaves when the core takes it; a new beat may enter in the same cycle.
  assign rx_stall = byte_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!rx_stall) begin
      byte_valid <= rx_valid;
    end
  end

  // Payload register carries no reset.
  always_ff @(posedge clk) begin
    if (!rx_stall && rx_valid) begin
      byte_data <= rx_byte;
    end
  end

endmodule

// ----- rtl/scl_line_core.sv -----
module scl_line_core
  import scl_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic [7:0] byte_data,
  input  logic       out_free,
  output logic       advance,
  output logic       emit,
  output result_t    result
);

  localparam int CW = $clog2(LINE_BYTES);
  localparam logic [CW-1:0] KEEP_MAX   = CW'(LINE_BYTES - 1);
  localparam logic [CW-1:0] PREFIX_CNT = CW'(PREFIX_LEN);

  logic [CW-1:0] byte_count;
  logic [CW-1:0] byte_count_next;
  logic [31:0]   prefix_bytes;
  logic [31:0]   prefix_bytes_next;
  logic [31:0]   value_accumulator;
  logic [31:0]   value_accumulator_next;
  logic          digits_open;
  logic          digits_open_next;

  logic          is_newline;
  logic          is_digit;
  logic [31:0]   digit_value;

  assign is_newline  = (byte_data == NEWLINE_CODE);
  assign is_digit    = (byte_data >= DIGIT_ZERO) && (byte_data <= DIGIT_NINE);
  assign digit_value = {24'd0, byte_data - DIGIT_ZERO};

  // A newline needs room in the result register; any other byte is always taken.
  assign advance = byte_valid && (!is_newline || out_free);
  assign emit    = advance && is_newline;

  // Classify the finished line from its prefix and count.
  always_comb begin
    result.kind  = KIND_INVALID;
    result.value = 32'd0;
    if (byte_count >= PREFIX_CNT) begin
      case (prefix_bytes)
        PREFIX_ROT: result.kind = KIND_ROT;
        PREFIX_TEM: result.kind = KIND_TEM;
        PREFIX_VAC: result.kind = KIND_VAC;
        default:    result.kind = KIND_INVALID;
      endcase
      if (result.kind != KIND_INVALID) begin
        result.value = value_accumulator;
      end
    end
  end

  // Line state update: prefix shift, then decimal accumulation by times ten plus digit.
  always_comb begin
    byte_count_next        = byte_count;
    prefix_bytes_next      = prefix_bytes;
    value_accumulator_next = value_accumulator;
    digits_open_next       = digits_open;
    if (is_newline) begin
      byte_count_next        = '0;
      prefix_bytes_next      = 32'd0;
      value_accumulator_next = 32'd0;
      digits_open_next       = 1'b1;
    end else if (byte_count < KEEP_MAX) begin
      if (byte_count < PREFIX_CNT) begin
        prefix_bytes_next = {prefix_bytes[23:0], byte_data};
      end else if (digits_open) begin
        if (is_digit) begin
          value_accumulator_next = (value_accumulator << 3) + (value_accumulator << 1)
                                   + digit_value;
        end else begin
          digits_open_next = 1'b0;
        end
      end
      byte_count_next = byte_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count        <= '0;
      prefix_bytes      <= 32'd0;
      value_accumulator <= 32'd0;
      digits_open       <= 1'b1;
    end else if (advance) begin
      byte_count        <= byte_count_next;
      prefix_bytes      <= prefix_bytes_next;
      value_accumulator <= value_accumulator_next;
      digits_open       <= digits_open_next;
    end
  end

endmodule

// ----- rtl/scl_out_stage.sv -----
module scl_out_stage
  import scl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        emit,
  input  result_t     result,
  output logic        out_free,
  output logic [1:0]  line_kind,
  output logic [31:0] line_value,
  output logic        res_valid,
  input  logic        res_stall
);

  // The register can load when it is empty or its beat leaves this cycle.
  assign out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      line_kind  <= result.kind;
      line_value <= result.value;
    end
  end

endmodule

// ----- rtl/serial_command_line_parser.sv -----
// Result path: an accepted newline beat passes the input register, then the result
// register, where its result beat is held while res_stall is high.
// Throughput: one byte per cycle; only a stalled result held in the result
// register holds back the next newline, and the bytes behind it wait in turn.
// Reset: synchronous and active high; it empties both registers and clears the line state.
module serial_command_line_parser
  import scl_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  rx_byte,
  input  logic        rx_valid,
  output logic        rx_stall,
  output logic [1:0]  line_kind,
  output logic [31:0] line_value,
  output logic        res_valid,
  input  logic        res_stall
);

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       advance;
  logic       emit;
  logic       out_free;
  result_t    result;

  // Input register.
  scl_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (rx_byte),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .advance   (advance),
    .byte_valid(byte_valid),
    .byte_data (byte_data)
  );

  // Line state and classification.
  scl_line_core #(
    .LINE_BYTES(LINE_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_data (byte_data),
    .out_free  (out_free),
    .advance   (advance),
    .emit      (emit),
    .result    (result)
  );

  // Result register.
  scl_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .emit      (emit),
    .result    (result),
    .out_free  (out_free),
    .line_kind (line_kind),
    .line_value(line_value),
    .res_valid (res_valid),
    .res_stall (res_stall)
  );

endmodule

// ----- bench/tb_serial_command_line_parser.sv -----
`timescale 1ns / 1ps

// Predicts the parser's line results and checks each result beat against them.
class line_scoreboard;
  int          kept;
  logic [31:0] prefix;
  logic [31:0] value_sum;
  bit          digits_on;
  scl_pkg::result_t awaited[$];
  int          errors;

  function new();
    clear_line();
    errors = 0;
  endfunction

  function void clear_line();
    kept      = 0;
    prefix    = '0;
    value_sum = '0;
    digits_on = 1'b1;
  endfunction

  // Update the line state with one accepted byte; a newline queues one result.
  function void note_byte(logic [7:0] b);
    scl_pkg::result_t r;
    if (b == scl_pkg::NEWLINE_CODE) begin
      r.kind  = scl_pkg::KIND_INVALID;
      r.value = '0;
      if (kept >= scl_pkg::PREFIX_LEN) begin
        case (prefix)
          scl_pkg::PREFIX_ROT: r.kind = scl_pkg::KIND_ROT;
          scl_pkg::PREFIX_TEM: r.kind = scl_pkg::KIND_TEM;
          scl_pkg::PREFIX_VAC: r.kind = scl_pkg::KIND_VAC;
          default: r.kind = scl_pkg::KIND_INVALID;
        endcase
        if (r.kind != scl_pkg::KIND_INVALID) begin
          r.value = value_sum;
        end
      end
      awaited.push_back(r);
      clear_line();
    end else if (kept < scl_pkg::LINE_BYTES_DEF - 1) begin
      // Bytes past the kept length fall through without any effect.
      if (kept < scl_pkg::PREFIX_LEN) begin
        prefix = {prefix[23:0], b};
      end else if (digits_on) begin
        if (b >= scl_pkg::DIGIT_ZERO && b <= scl_pkg::DIGIT_NINE) begin
          value_sum = value_sum * 32'd10 + 32'(b - scl_pkg::DIGIT_ZERO);
        end else begin
          digits_on = 1'b0;
        end
      end
      kept++;
    end
  endfunction

  // Compare one result beat with the oldest predicted line result.
  function void check_result(logic [1:0] kind, logic [31:0] value);
    scl_pkg::result_t want;
    if (awaited.size() == 0) begin
      $error("line_kind: expected no result, actual %0d (line_value %0d)", kind, value);
      errors++;
      return;
    end
    want = awaited.pop_front();
    if (kind !== want.kind) begin
      $error("line_kind: expected %0d, actual %0d", want.kind, kind);
      errors++;
    end
    if (value !== want.value) begin
      $error("line_value: expected %0d, actual %0d", want.value, value);
      errors++;
    end
  endfunction
endclass

module tb_serial_command_line_parser;
  import scl_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_BYTES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [7:0]  rx_byte = '0;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  logic [1:0]  line_kind;
  logic [31:0] line_value;
  logic        res_valid;
  logic        res_stall = 1'b0;

  line_scoreboard board = new();
  int max_rx_gap = 0;
  int max_res_hold = 0;
  int bytes_sent = 0;
  int cycles = 0;

  always #HALF_PERIOD clk = ~clk;

  serial_command_line_parser uut (
    .clk(clk),
    .rst(rst),
    .rx_byte(rx_byte),
    .rx_valid(rx_valid),
    .rx_stall(rx_stall),
    .line_kind(line_kind),
    .line_value(line_value),
    .res_valid(res_valid),
    .res_stall(res_stall)
  );

  // Watch both channels at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) begin
        board.check_result(line_kind, line_value);
      end
      if (rx_valid && !rx_stall) begin
        board.note_byte(rx_byte);
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("serial_command_line_parser: mismatch");
      $finish;
    end
  end

  // The result side holds stall for a random number of cycles before each beat.
  initial begin
    int hold;
    while (rst) @(negedge clk);
    forever begin
      hold = $urandom_range(0, max_res_hold);
      if (hold > 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        res_stall <= 1'b0;
      end
      do @(posedge clk); while (!(res_valid && !res_stall));
      @(negedge clk);
    end
  end

  // Offer one byte after a random gap and wait until the beat is taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, max_rx_gap);
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_byte  <= b;
    rx_valid <= 1'b1;
    do @(posedge clk); while (rx_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  function automatic logic [7:0] other_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == NEWLINE_CODE);
    return b;
  endfunction

  // One random line: mostly commands with random digits, some with a damaged
  // prefix, some short, some long and some plain noise.
  task automatic random_line();
    logic [7:0]  text[$];
    logic [31:0] head;
    int          mode;
    int          len;
    mode = $urandom_range(0, 9);
    case ($urandom_range(0, 2))
      0: head = PREFIX_ROT;
      1: head = PREFIX_TEM;
      default: head = PREFIX_VAC;
    endcase
    if (mode <= 6) begin
      for (int i = 0; i < PREFIX_LEN; i++) begin
        text.push_back(head[31 - 8 * i -: 8]);
      end
      if (mode == 6) begin
        text[$urandom_range(0, PREFIX_LEN - 1)] = other_byte();
      end
      // Long digit runs overflow the value and the kept line length.
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 34) : $urandom_range(0, 10);
      repeat (len) text.push_back(8'(DIGIT_ZERO + $urandom_range(0, 9)));
      if ($urandom_range(0, 2) == 0) begin
        text.push_back(other_byte());
        repeat ($urandom_range(0, 4)) text.push_back(8'(DIGIT_ZERO + $urandom_range(0, 9)));
      end
    end else if (mode == 7) begin
      repeat ($urandom_range(0, 3)) text.push_back(other_byte());
    end else if (mode == 8) begin
      repeat ($urandom_range(1, 45)) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 45)) text.push_back(other_byte());
    end
    text.push_back(NEWLINE_CODE);
    foreach (text[i]) begin
      send_byte(text[i]);
    end
  endtask

  initial begin
    int start;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed lines: empty, short, value cut by a non-digit, no digits,
    // unknown prefix, and a zero byte ending the value.
    max_rx_gap   = 3;
    max_res_hold = 3;
    send_text("\n");
    send_text("TE\n");
    send_text("ROT 9/7\n");
    send_text("VAC \n");
    send_byte(8'hFF);
    send_text("OT 1\n");
    send_text("TEM 3");
    send_byte(8'h00);
    send_text("4\n");

    // Random lines under four idling patterns, one of them with no idling.
    for (int phase = 0; phase < 4; phase++) begin
      max_rx_gap   = (phase == 0 || phase == 3) ? 18 : 0;
      max_res_hold = (phase == 0 || phase == 2) ? 18 : 0;
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
        random_line();
      end
    end
    rx_valid <= 1'b0;

    // Drain the remaining results, then give the block time to show extras.
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("serial_command_line_parser: match");
    end else begin
      $display("serial_command_line_parser: mismatch");
    end
    $finish;
  end
endmodule
